[src/box_downsample_2x2_int16_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 box downsampler
// Concurrent checks, clocked and reset-qualified, that compile away with
// ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_2X2_INT16_CORE_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_INT16_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define BDS2_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BDS2_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDS2_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define BDS2_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[src/bds2_pkg.sv]
// ----------------------------------------------------------------------------
// bds2_pkg
// Sizes, register codes and shared types of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package bds2_pkg;

  localparam int MAX_SOURCE_WIDTH  = 2048;
  localparam int MAX_SOURCE_HEIGHT = 2048;

  localparam int COL_W    = $clog2(MAX_SOURCE_WIDTH);
  localparam int ROW_W    = $clog2(MAX_SOURCE_HEIGHT);
  localparam int ADDR_W   = COL_W;
  localparam int DIM_W    = 12;
  localparam int SAMPLE_W = 16;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int TOTAL_W  = PAIR_W + 2;
  localparam int CHAN_W   = 2;
  localparam int INDEX_W  = 2;

  localparam logic [INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [DIM_W-1:0]  RESET_WIDTH    = 12'd640;
  localparam logic [DIM_W-1:0]  RESET_HEIGHT   = 12'd480;
  localparam logic [CHAN_W-1:0] RESET_CHANNELS = 2'd1;
  localparam logic [CHAN_W-1:0] ONE_CHANNEL    = 2'd1;

  typedef struct packed {
    logic                     we;
    logic                     re;
    logic [ADDR_W-1:0]        addr;
    logic signed [PAIR_W-1:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic signed [PAIR_W-1:0] pair;
    logic                     ch;
    logic                     row_end;
    logic                     frame_end;
  } out_item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[src/bds2_line_ram.sv]
// ----------------------------------------------------------------------------
// bds2_line_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bds2_line_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/bds2_scan.sv]
// ----------------------------------------------------------------------------
// bds2_scan
// Configuration registers, raster position and left-sample hold; issues
// line store writes on even rows and reads on odd rows.
// ----------------------------------------------------------------------------
module bds2_scan
  import bds2_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [INDEX_W-1:0]         cfg_index,
  input  logic [DIM_W-1:0]           cfg_data,
  input  logic                       in_accept,
  input  logic signed [SAMPLE_W-1:0] sample,
  output store_req_t                 req,
  output logic                       item_valid,
  output out_item_t                  item
);

  logic [DIM_W-1:0]           source_width;
  logic [DIM_W-1:0]           source_height;
  logic [CHAN_W-1:0]          channel_count;
  logic [COL_W-1:0]           column;
  logic [ROW_W-1:0]           row;
  logic                       phase;
  logic signed [SAMPLE_W-1:0] pending [2];

  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [DIM_W-2:0]   dst_w;
  logic [DIM_W-2:0]   dst_h;
  logic               two_ch;
  logic               in_area;
  logic               last_ch;
  logic               last_col;
  logic               last_row;
  logic [COL_W-2:0]   col_half;
  logic signed [SAMPLE_W-1:0] left;

  always_comb begin
    w_eff    = clamp_dim(source_width, DIM_W'(MAX_SOURCE_WIDTH));
    h_eff    = clamp_dim(source_height, DIM_W'(MAX_SOURCE_HEIGHT));
    dst_w    = w_eff[DIM_W-1:1];
    dst_h    = h_eff[DIM_W-1:1];
    two_ch   = (channel_count != ONE_CHANNEL);
    in_area  = (DIM_W'(column) < {dst_w, 1'b0}) && (DIM_W'(row) < {dst_h, 1'b0});
    last_ch  = !two_ch || phase;
    last_col = (DIM_W'(column) + DIM_W'(1)) >= w_eff;
    last_row = (DIM_W'(row) + DIM_W'(1)) >= h_eff;
    col_half = column[COL_W-1:1];
    left     = pending[phase];

    req.addr  = two_ch ? {col_half, phase} : {1'b0, col_half};
    req.wdata = {left[SAMPLE_W-1], left} + {sample[SAMPLE_W-1], sample};
    req.we    = in_accept && in_area && column[0] && !row[0];
    req.re    = in_accept && in_area && column[0] && row[0];

    item_valid     = req.re;
    item.pair      = req.wdata;
    item.ch        = phase;
    item.row_end   = (((DIM_W-1)'(col_half) + (DIM_W-1)'(1)) == dst_w) && (phase == two_ch);
    item.frame_end = item.row_end &&
                     (((DIM_W-1)'(row[ROW_W-1:1]) + (DIM_W-1)'(1)) == dst_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RESET_WIDTH;
      source_height <= RESET_HEIGHT;
      channel_count <= RESET_CHANNELS;
      column        <= '0;
      row           <= '0;
      phase         <= 1'b0;
      pending[0]    <= '0;
      pending[1]    <= '0;
    end else begin
      if (in_accept && in_area && !column[0]) begin
        pending[phase] <= sample;
      end
      if (cfg_we && (cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT ||
                     cfg_index == REG_CHANNEL_COUNT)) begin
        unique case (cfg_index)
          REG_SOURCE_WIDTH:  source_width  <= cfg_data;
          REG_SOURCE_HEIGHT: source_height <= cfg_data;
          default:           channel_count <= cfg_data[CHAN_W-1:0];
        endcase
        column <= '0;
        row    <= '0;
        phase  <= 1'b0;
      end else if (in_accept) begin
        if (last_ch) begin
          phase <= 1'b0;
          if (last_col) begin
            column <= '0;
            row    <= last_row ? '0 : row + ROW_W'(1);
          end else begin
            column <= column + COL_W'(1);
          end
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

endmodule

[src/bds2_reduce.sv]
// ----------------------------------------------------------------------------
// bds2_reduce
// Adds the stored even-row pair to the odd-row pair, rounds, and holds the
// result in the output register.
// ----------------------------------------------------------------------------
`include "box_downsample_2x2_int16_core_macros.svh"

module bds2_reduce
  import bds2_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  out_item_t                  item,
  input  logic signed [PAIR_W-1:0]   rdata,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] average,
  output logic                       channel_index,
  output logic                       row_end,
  output logic                       frame_end
);

  logic                      s1_valid;
  out_item_t                 s1_item;
  logic                      s1_advance;
  logic signed [TOTAL_W-1:0] total;

  always_comb begin
    s1_advance = s1_valid && (!out_valid || out_ready);
    in_ready   = !s1_valid || s1_advance;
    total      = {{2{rdata[PAIR_W-1]}}, rdata} +
                 {{2{s1_item.pair[PAIR_W-1]}}, s1_item.pair} + TOTAL_W'(2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_valid) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      s1_item <= item;
    end
    if (s1_advance) begin
      average       <= total[PAIR_W:2];
      channel_index <= s1_item.ch;
      row_end       <= s1_item.row_end;
      frame_end     <= s1_item.frame_end;
    end
  end

  `BDS2_ASSERT_IMPLY(a_frame_end_on_row_end, clk, rst, out_valid && frame_end, row_end,
    "frame end without row end")
  `BDS2_ASSERT_NEXT(a_stage_kept, clk, rst, s1_valid && out_valid && !out_ready,
    s1_valid && $stable(s1_item.pair), "pending sum lost while output stalled")
  `BDS2_ASSERT_IMPLY(a_no_overrun, clk, rst, item_valid, in_ready,
    "item entered a busy stage")

endmodule

[src/box_downsample_2x2_int16_core.sv]
// ----------------------------------------------------------------------------
// box_downsample_2x2_int16_core
// Downsamples a raster stream of signed 16-bit samples by two in each
// direction with a rounded 2x2 box mean.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready, sample) carry one sample each in raster
// order with channels interleaved. Output beats (out_valid/out_ready) carry
// average, channel_index, row_end and frame_end. Configuration beats
// (cfg_valid/cfg_ready, cfg_index, cfg_data) set width, height and channel
// count; cfg_ready is always high, a write to width, height or channel count
// restarts the frame position, and a write to the spare index is dropped.
// One sample is taken per cycle while in_ready is high; the only shared
// resource is the single port of the line store, which an even row writes
// and an odd row reads. A block's result passes from the sum stage to the
// output register. Odd last columns and rows are consumed and dropped.
// When out_ready is low, the result holds in the output register, one more
// block may wait in the sum stage, and in_ready falls once both are full.
// Reset restores 640 x 480, one channel, and position zero; the line store
// needs no clearing because every entry is written before it is read.
// ----------------------------------------------------------------------------
module box_downsample_2x2_int16_core
  import bds2_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] average,
  output logic                       channel_index,
  output logic                       row_end,
  output logic                       frame_end,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [INDEX_W-1:0]         cfg_index,
  input  logic [DIM_W-1:0]           cfg_data
);

  store_req_t               req;
  out_item_t                item;
  logic                     item_valid;
  logic                     in_accept;
  logic signed [PAIR_W-1:0] rdata;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;

  bds2_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .sample     (sample),
    .req        (req),
    .item_valid (item_valid),
    .item       (item)
  );

  bds2_line_ram #(
    .DEPTH  (MAX_SOURCE_WIDTH),
    .DATA_W (PAIR_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  bds2_reduce u_reduce (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .rdata         (rdata),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .average       (average),
    .channel_index (channel_index),
    .row_end       (row_end),
    .frame_end     (frame_end)
  );

endmodule
